@@ sv/bgra_box_downscale_pow2_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the BGRA box downscaler.
// Each macro expands to one labeled concurrent assertion on clk, off in rst.
// ---------------------------------------------------------------------------
`ifndef BGRA_BOX_DOWNSCALE_POW2_ASSERT_SVH
`define BGRA_BOX_DOWNSCALE_POW2_ASSERT_SVH

// Condition implies a property in the same cycle.
`define BBD_ASSERT_NOW(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Condition implies a property in the next cycle.
`define BBD_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/bbd_pkg.sv @@
// ---------------------------------------------------------------------------
// bbd_pkg
// Types and constants shared by the BGRA box downscaler and its interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

  // Pixel packing: four 8-bit channels, blue in the low byte.
  localparam int PIX_W  = 32;
  localparam int LANES  = 4;
  localparam int CH_W   = 8;
  localparam int SUM_W  = 16;

  // Configuration register widths.
  localparam int DIM_W  = 13;
  localparam int LOG_W  = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes (byte address bits 3:2).
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LOG2_H = 2'd2;
  localparam logic [1:0] REG_LOG2_V = 2'd3;

  // Limits.
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MAX_LOG2      = 8;

  // Result queue depth.
  localparam int OFIFO_DEPTH = 4;

  // Four 16-bit channel sums, blue in lane 0.
  typedef logic [LANES-1:0][SUM_W-1:0] sum_t;

  // One result item.
  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;
  } result_t;

  // Per-pixel position flags carried into the accumulate stage.
  typedef struct packed {
    logic last_col;
    logic last_row;
    logic first_row;
    logic at_right;
    logic at_bottom;
    logic fwd;
  } stage_flags_t;

endpackage

`default_nettype wire

@@ sv/bbd_pixel_if.sv @@
// ---------------------------------------------------------------------------
// bbd_pixel_if
// Valid/ready channel that carries one BGRA input pixel per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbd_pixel_if import bbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ sv/bbd_result_if.sv @@
// ---------------------------------------------------------------------------
// bbd_result_if
// Valid/ready channel that carries one averaged pixel with its row marks.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbd_result_if import bbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output out_pixel, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

@@ sv/bgra_box_downscale_pow2.sv @@
// ---------------------------------------------------------------------------
// bgra_box_downscale_pow2
// Power-of-two box downscaler for BGRA pixels in raster order, with a
// column-sum line store held in a synchronous memory.
// ---------------------------------------------------------------------------
//  Channel  | Dir | Handshake              | Payload
//  pixels   | in  | valid/ready            | pixel[31:0]
//  blocks   | out | valid/ready            | out_pixel[31:0], row_end, frame_end
//  APB      | in  | psel/penable, pready=1 | 4 registers at byte address 4*i
//
// One pixel per clock is accepted while the result queue has room; a block's
// result passes from the request stage through the accumulate stage into the
// result queue. The rate is set by the read-modify-write of the column store,
// with forwarding for back-to-back accesses to the same block column. Reset
// clears control state; the column store needs no clearing pass, because the
// first row of every block row ignores what the store holds. A four-entry
// result queue absorbs output stalls; input is held off once the queue holds
// three results while the accumulate stage is busy, or holds four.
// ---------------------------------------------------------------------------
`default_nettype none

module bgra_box_downscale_pow2 import bbd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  bbd_pixel_if.sink               pixels,
  bbd_result_if.source            blocks,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(OFIFO_DEPTH);
  localparam int CW = $clog2(OFIFO_DEPTH + 1);
  localparam logic [CW-1:0] FIFO_FULL = CW'(OFIFO_DEPTH);
  localparam logic [CW-1:0] FIFO_LAST = CW'(OFIFO_DEPTH - 1);

  // Configuration registers.
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [LOG_W-1:0] cfg_log2_h;
  logic [LOG_W-1:0] cfg_log2_v;
  logic             cfg_write;

  // Position and accumulation state.
  logic [XW-1:0] x;
  logic [11:0]   y;
  sum_t          brs;

  // Accumulate stage registers.
  logic             b_valid;
  logic [PIX_W-1:0] b_pixel;
  logic [8:0]       b_weight;
  logic [XW-1:0]    b_bx;
  stage_flags_t     b_flags;
  sum_t             b_fwd_data;

  // Column store.
  sum_t col_mem [MAX_WIDTH];
  sum_t col_rdata;

  // Result queue.
  result_t       fifo [OFIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  // Derived geometry.
  logic [WW-1:0]    w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [LOG_W-1:0] mx;
  logic [LOG_W-1:0] my;
  logic [LOG_W-1:0] s;
  logic [7:0]       bxm;
  logic [7:0]       bym;
  logic [7:0]       half;
  logic [7:0]       wrem;
  logic [7:0]       hrem;

  // Request stage signals.
  logic          accept;
  logic          at_right;
  logic          at_bottom;
  logic          last_col;
  logic          last_row;
  logic          first_row;
  logic [8:0]    wc;
  logic [8:0]    wr;
  logic [XW-1:0] bx_a;

  // Accumulate stage signals.
  sum_t             acc;
  sum_t             col_sum;
  sum_t             total;
  sum_t             wr_data;
  logic [PIX_W-1:0] avg_pixel;

  // APB port: writes restart the frame, reads return the raw register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DIM_W'(1);
      cfg_height <= DIM_W'(1);
      cfg_log2_h <= LOG_W'(1);
      cfg_log2_v <= LOG_W'(1);
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_height <= pwdata[DIM_W-1:0];
        REG_LOG2_H: cfg_log2_h <= pwdata[LOG_W-1:0];
        REG_LOG2_V: cfg_log2_v <= pwdata[LOG_W-1:0];
        default:    cfg_width  <= cfg_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = PDATA_W'(cfg_width);
      REG_HEIGHT: prdata = PDATA_W'(cfg_height);
      REG_LOG2_H: prdata = PDATA_W'(cfg_log2_h);
      REG_LOG2_V: prdata = PDATA_W'(cfg_log2_v);
      default:    prdata = '0;
    endcase
  end

  // Saturate the image size and the factors.
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_height;
    end
    mx   = (cfg_log2_h > LOG_W'(MAX_LOG2)) ? LOG_W'(MAX_LOG2) : cfg_log2_h;
    my   = (cfg_log2_v > LOG_W'(MAX_LOG2) - mx) ? LOG_W'(MAX_LOG2) - mx : cfg_log2_v;
    s    = mx + my;
    bxm  = 8'((9'd1 << mx) - 9'd1);
    bym  = 8'((9'd1 << my) - 9'd1);
    half = (s == '0) ? 8'd0 : 8'(9'd1 << (s - LOG_W'(1)));
    wrem = 8'(w_eff) & bxm;
    hrem = h_eff[7:0] & bym;
  end

  // Request stage: position flags, edge weight and column store read.
  assign pixels.ready = (count < FIFO_LAST) || ((count == FIFO_LAST) && !b_valid);
  assign accept       = pixels.valid && pixels.ready;

  always_comb begin
    at_right  = (WW'(x) == w_eff - WW'(1));
    at_bottom = ({1'b0, y} == h_eff - DIM_W'(1));
    last_col  = at_right || ((8'(x) & bxm) == bxm);
    last_row  = at_bottom || ((y[7:0] & bym) == bym);
    first_row = ((y[7:0] & bym) == 8'd0);
    wc = (at_right && wrem != 8'd0) ? 9'(bxm) + 9'd1 - 9'(wrem - 8'd1) : 9'd1;
    wr = (at_bottom && hrem != 8'd0) ? 9'(bym) + 9'd1 - 9'(hrem - 8'd1) : 9'd1;
    bx_a = x >> mx;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_rdata <= col_mem[bx_a];
    end
  end

  // Position counters; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      x <= '0;
      y <= '0;
    end else if (accept) begin
      if (at_right) begin
        x <= '0;
        y <= at_bottom ? 12'd0 : y + 12'd1;
      end else begin
        x <= x + XW'(1);
      end
    end
  end

  // Stage register between request and accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pixel            <= pixels.pixel;
      b_weight           <= 9'(18'(wc) * 18'(wr));
      b_bx               <= bx_a;
      b_flags.last_col   <= last_col;
      b_flags.last_row   <= last_row;
      b_flags.first_row  <= first_row;
      b_flags.at_right   <= at_right;
      b_flags.at_bottom  <= at_bottom;
      // The store read above misses a write at this same edge.
      b_flags.fwd        <= b_valid && b_flags.last_col && (b_bx == bx_a);
      b_fwd_data         <= wr_data;
    end
  end

  // Accumulate stage: weighted add, column sum and rounding, per lane.
  always_comb begin
    col_sum = b_flags.fwd ? b_fwd_data : col_rdata;
    for (int k = 0; k < LANES; k++) begin
      acc[k] = brs[k] + 16'(17'(b_pixel[CH_W*k +: CH_W]) * 17'(b_weight));
      total[k] = acc[k] + (b_flags.first_row ? 16'd0 : col_sum[k]);
      avg_pixel[CH_W*k +: CH_W] = 8'((17'(total[k]) + 17'(half)) >> s);
    end
    wr_data = b_flags.last_row ? '0 : total;
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_flags.last_col) begin
      col_mem[b_bx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      brs <= '0;
    end else if (b_valid) begin
      brs <= b_flags.last_col ? '0 : acc;
    end
  end

  // Result queue.
  assign push = b_valid && b_flags.last_col && b_flags.last_row;
  assign pop  = blocks.valid && blocks.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].out_pixel <= avg_pixel;
      fifo[wr_ptr].row_end   <= b_flags.at_right;
      fifo[wr_ptr].frame_end <= b_flags.at_right && b_flags.at_bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign blocks.valid     = (count != '0);
  assign blocks.out_pixel = fifo[rd_ptr].out_pixel;
  assign blocks.row_end   = fifo[rd_ptr].row_end;
  assign blocks.frame_end = fifo[rd_ptr].frame_end;

  // Assertions.
`include "bgra_box_downscale_pow2_assert.svh"

  `BBD_ASSERT_NOW(a_fifo_room, push && !pop, count != FIFO_FULL, "result queue overflow")
  `BBD_ASSERT_NOW(a_frame_wrap, b_valid && b_flags.at_right && b_flags.at_bottom, (x == '0) && (y == 12'd0), "position did not wrap at frame end")
  `BBD_ASSERT_NOW(a_fwd_source, b_valid && b_flags.fwd, $past(b_valid && b_flags.last_col), "forward without a preceding store write")
  `BBD_ASSERT_NEXT(a_brs_clear, b_valid && b_flags.last_col, brs == '0, "block row sum not cleared")

endmodule

`default_nettype wire
